// File: rtl/core/pcmsp_pkg.sv
// ----------------------------------------------------------------------------
// pcmsp_pkg
// types, constants and command structs shared by the sample player modules
// ----------------------------------------------------------------------------
package pcmsp_pkg;

	localparam int VOICES           = 16;
	localparam int SAMPLE_ADDR_BITS = 18;
	localparam int REG_ADDR_BITS    = 11;
	localparam int VOICE_BITS       = 4;
	localparam int REG_DEPTH        = 1 << REG_ADDR_BITS;
	localparam int SMP_DEPTH        = 1 << SAMPLE_ADDR_BITS;
	localparam int MIX_W            = 20;

	// register offsets within a voice
	localparam logic [7:0] OFS_VOLL  = 8'h02;
	localparam logic [7:0] OFS_VOLR  = 8'h03;
	localparam logic [7:0] OFS_ADDRM = 8'h04;
	localparam logic [7:0] OFS_ADDRH = 8'h05;
	localparam logic [7:0] OFS_END   = 8'h06;
	localparam logic [7:0] OFS_DELTA = 8'h07;
	localparam logic [7:0] OFS_LOOPL = 8'h84;
	localparam logic [7:0] OFS_LOOPH = 8'h85;
	localparam logic [7:0] OFS_FLAGS = 8'h86;
	localparam logic [7:0] SMP_BIAS  = 8'h80;

	// item kinds
	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_TICK  = 2'd2;
	localparam logic [1:0] KIND_LOAD  = 2'd3;

	// configuration register indexes
	localparam logic [0:0] CFG_BANK_SHIFT = 1'd0;
	localparam logic [0:0] CFG_BANK_MASK  = 1'd1;

	// register fields fetched for one voice
	typedef enum logic [3:0] {
		F_FLAGS = 4'd0,
		F_ADDRH = 4'd1,
		F_ADDRM = 4'd2,
		F_LOOPH = 4'd3,
		F_LOOPL = 4'd4,
		F_END   = 4'd5,
		F_DELTA = 4'd6,
		F_VOLL  = 4'd7,
		F_VOLR  = 4'd8
	} field_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [10:0] reg_address;
		logic [7:0]  data_byte;
		logic [17:0] sample_address;
	} in_item_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic signed [19:0] left_mix;
		logic signed [19:0] right_mix;
	} out_item_t;

	// commands from controller to datapath
	typedef struct packed {
		logic                  clr_mix;    // start of tick
		logic                  host_wr;    // host register write
		logic                  host_rd;    // host register read
		logic                  smp_load;   // sample memory write
		logic                  fetch;      // issue register read of field
		field_t                fld;        // field being read
		logic                  capture;    // capture returned field
		field_t                cap_fld;
		logic                  decide;     // evaluate end/loop, start sample read
		logic                  mix;        // accumulate products
		logic                  wb_flags;   // write back flags
		logic                  wb_addrm;
		logic                  wb_addrh;
		logic [VOICE_BITS-1:0] voice;
	} cmd_t;

	typedef struct packed {
		logic stopped;  // voice is inactive, skip it
	} stat_t;

	function automatic logic [7:0] field_ofs(field_t f);
		logic [7:0] r;
		r = OFS_FLAGS;
		unique case (f)
			F_FLAGS: r = OFS_FLAGS;
			F_ADDRH: r = OFS_ADDRH;
			F_ADDRM: r = OFS_ADDRM;
			F_LOOPH: r = OFS_LOOPH;
			F_LOOPL: r = OFS_LOOPL;
			F_END:   r = OFS_END;
			F_DELTA: r = OFS_DELTA;
			F_VOLL:  r = OFS_VOLL;
			F_VOLR:  r = OFS_VOLR;
			default: r = OFS_FLAGS;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/pcmsp_datapath.sv
// ----------------------------------------------------------------------------
// pcmsp_datapath
// register ram with clearing pass, sample memory, voice step and mixer
// ----------------------------------------------------------------------------
module pcmsp_datapath import pcmsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  in_item_t   item,
	input  in_item_t   held,
	input  logic [4:0] bank_shift,
	input  logic [7:0] bank_mask,
	output stat_t      stat,
	output logic       clr_busy,
	output out_item_t  result
);

	logic [7:0] reg_mem [REG_DEPTH];
	logic [7:0] smp_mem [SMP_DEPTH];
	logic [7:0] frac_q [VOICES];

	logic [REG_ADDR_BITS:0]   clr_cnt_q;
	logic [REG_ADDR_BITS-1:0] ra_base;
	logic [7:0] rd_q, smp_q;
	logic [7:0] flags_q, addrh_q, addrm_q, looph_q, loopl_q, end_q, delta_q, voll_q, volr_q;
	logic [23:0] addr_q;
	logic        stop_q;
	logic signed [MIX_W-1:0] left_q, right_q;

	assign clr_busy = !clr_cnt_q[REG_ADDR_BITS];
	assign ra_base  = REG_ADDR_BITS'({cmd.voice, 3'b000});

	// register ram port: clearing pass, host access, voice access
	logic                     wr_en;
	logic [REG_ADDR_BITS-1:0] wr_a, rd_a;
	logic [7:0]               wr_d;
	always_comb begin
		wr_en = 1'b0;
		wr_a  = '0;
		wr_d  = 8'hff;
		rd_a  = ra_base + REG_ADDR_BITS'(field_ofs(cmd.fld));
		if (clr_busy) begin
			wr_en = 1'b1;
			wr_a  = clr_cnt_q[REG_ADDR_BITS-1:0];
		end else if (cmd.host_wr) begin
			wr_en = 1'b1;
			wr_a  = item.reg_address;
			wr_d  = item.data_byte;
		end else if (cmd.wb_flags) begin
			wr_en = 1'b1;
			wr_a  = ra_base + REG_ADDR_BITS'(OFS_FLAGS);
			wr_d  = flags_q | {7'd0, stop_q};
		end else if (cmd.wb_addrm) begin
			wr_en = 1'b1;
			wr_a  = ra_base + REG_ADDR_BITS'(OFS_ADDRM);
			wr_d  = addr_q[15:8];
		end else if (cmd.wb_addrh) begin
			wr_en = 1'b1;
			wr_a  = ra_base + REG_ADDR_BITS'(OFS_ADDRH);
			wr_d  = addr_q[23:16];
		end
		// read requests use the held address
		if (cmd.host_rd) rd_a = held.reg_address;
	end

	always_ff @(posedge clk) begin
		if (wr_en) reg_mem[wr_a] <= wr_d;
		rd_q <= reg_mem[rd_a];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (clr_busy) clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	// capture fields of the current voice
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			unique case (cmd.cap_fld)
				F_FLAGS: flags_q <= rd_q;
				F_ADDRH: addrh_q <= rd_q;
				F_ADDRM: addrm_q <= rd_q;
				F_LOOPH: looph_q <= rd_q;
				F_LOOPL: loopl_q <= rd_q;
				F_END:   end_q   <= rd_q;
				F_DELTA: delta_q <= rd_q;
				F_VOLL:  voll_q  <= rd_q;
				F_VOLR:  volr_q  <= rd_q;
				default: flags_q <= rd_q;
			endcase
		end
	end
	assign stat.stopped = flags_q[0];

	// end check, sample fetch address, address advance
	logic [23:0] cur_addr, nxt_addr;
	logic        hit_end, stop_now;
	logic [31:0] bank;
	logic [SAMPLE_ADDR_BITS-1:0] sidx;
	always_comb begin
		cur_addr = {addrh_q, addrm_q, frac_q[cmd.voice]};
		hit_end  = (addrh_q == (end_q + 8'd1));
		stop_now = hit_end && flags_q[1];
		nxt_addr = cur_addr;
		if (hit_end && !flags_q[1]) nxt_addr = {looph_q, loopl_q, 8'd0};
		bank = 32'(flags_q & bank_mask) << bank_shift;
		sidx = SAMPLE_ADDR_BITS'(bank + 32'(nxt_addr[23:8]));
	end

	always_ff @(posedge clk) begin
		if (cmd.smp_load) smp_mem[item.sample_address] <= item.data_byte;
		if (cmd.decide) smp_q <= smp_mem[sidx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) frac_q[i] <= '0;
			stop_q <= 1'b0;
		end else if (cmd.decide) begin
			stop_q <= stop_now;
			if (stop_now) frac_q[cmd.voice] <= '0;
			else frac_q[cmd.voice] <= nxt_addr[7:0] + delta_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) addr_q <= stop_now ? cur_addr : nxt_addr + 24'(delta_q);
	end

	// mixer
	logic signed [8:0]  sv;
	logic signed [17:0] pl, pr;
	assign sv = $signed({1'b0, smp_q}) - $signed({1'b0, SMP_BIAS});
	assign pl = sv * $signed({1'b0, voll_q});
	assign pr = sv * $signed({1'b0, volr_q});

	always_ff @(posedge clk) begin
		if (cmd.clr_mix) begin
			left_q  <= '0;
			right_q <= '0;
		end else if (cmd.mix && !stop_q) begin
			left_q  <= left_q + MIX_W'(pl);
			right_q <= right_q + MIX_W'(pr);
		end
	end

	assign result.read_data = rd_q;
	assign result.left_mix  = left_q;
	assign result.right_mix = right_q;

endmodule

// File: rtl/core/pcmsp_ctrl.sv
// ----------------------------------------------------------------------------
// pcmsp_ctrl
// sequencer: handshake, per-voice field fetch, decide, mix and write-back
// ----------------------------------------------------------------------------
module pcmsp_ctrl import pcmsp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output out_item_t out_item,
	output in_item_t held,
	input  out_item_t dp_result,
	input  stat_t    stat,
	input  logic     clr_busy,
	output cmd_t     cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_READ   = 8'b0000_0010,
		S_FETCH  = 8'b0000_0100,
		S_DECIDE = 8'b0000_1000,
		S_MIX    = 8'b0001_0000,
		S_WB     = 8'b0010_0000,
		S_DONE   = 8'b0100_0000,
		S_RDONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [VOICE_BITS-1:0] voice_q;
	logic [3:0] step_q;
	logic [1:0] wb_q;
	in_item_t held_q;
	out_item_t out_q;
	logic out_v_q;
	logic kind_tick;

	assign held      = held_q;
	assign out_valid = out_v_q;
	assign out_item  = out_q;
	assign in_ready  = (state_q == S_IDLE) && !clr_busy && (!out_v_q || out_ready);
	assign kind_tick = held_q.kind == KIND_TICK;

	// commands for the datapath
	always_comb begin
		cmd = '0;
		cmd.voice   = voice_q;
		cmd.fld     = field_t'(step_q);
		cmd.cap_fld = field_t'(step_q - 4'd1);
		unique case (state_q)
			S_READ:   cmd.host_rd = 1'b1;
			S_FETCH: begin
				cmd.fetch   = 1'b1;
				cmd.capture = step_q != 4'd0;
			end
			S_DECIDE: cmd.decide = 1'b1;
			S_MIX:    cmd.mix = 1'b1;
			S_WB: begin
				cmd.wb_flags = wb_q == 2'd0;
				cmd.wb_addrm = wb_q == 2'd1;
				cmd.wb_addrh = wb_q == 2'd2;
			end
			default: ;
		endcase
		if (in_valid && in_ready) begin
			cmd.host_wr  = in_item.kind == KIND_WRITE;
			cmd.smp_load = in_item.kind == KIND_LOAD;
			cmd.clr_mix  = in_item.kind == KIND_TICK;
		end
	end

	logic last_voice;
	assign last_voice = voice_q == VOICE_BITS'(VOICES - 1);

	// result becomes valid: write and load at once, read and tick when done
	logic out_set;
	assign out_set = (state_q == S_RDONE) || (state_q == S_DONE) ||
		(in_valid && in_ready && in_item.kind != KIND_READ && in_item.kind != KIND_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			voice_q <= '0;
			step_q  <= '0;
			wb_q    <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_set) out_v_q <= 1'b1;
			else if (out_v_q && out_ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					unique case (in_item.kind)
						KIND_READ: state_q <= S_READ;
						KIND_TICK: begin
							state_q <= S_FETCH;
							voice_q <= '0;
							step_q  <= '0;
						end
						default: ;
					endcase
				end
				S_READ:  state_q <= S_RDONE;
				S_RDONE: state_q <= S_IDLE;
				S_FETCH: begin
					// flags come back first; a stopped voice skips the rest
					if (step_q == 4'd2 && stat.stopped) begin
						step_q <= '0;
						if (last_voice) state_q <= S_DONE;
						else voice_q <= voice_q + 1'b1;
					end else if (step_q == 4'd9) begin
						state_q <= S_DECIDE;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				S_DECIDE: state_q <= S_MIX;
				S_MIX: begin
					state_q <= S_WB;
					wb_q    <= '0;
				end
				S_WB: begin
					if (wb_q == 2'd2) begin
						step_q <= '0;
						if (last_voice) state_q <= S_DONE;
						else begin
							state_q <= S_FETCH;
							voice_q <= voice_q + 1'b1;
						end
					end else wb_q <= wb_q + 2'd1;
				end
				S_DONE:  state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold accepted item and form result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			held_q <= in_item;
			if (in_item.kind != KIND_READ && in_item.kind != KIND_TICK) out_q <= '0;
		end
		if (state_q == S_RDONE) out_q <= '{read_data: dp_result.read_data,
			left_mix: '0, right_mix: '0};
		if (state_q == S_DONE && kind_tick) out_q <= '{read_data: 8'd0,
			left_mix: dp_result.left_mix, right_mix: dp_result.right_mix};
	end

endmodule

// File: rtl/core/pcm_sample_player_16ch_top.sv
// ----------------------------------------------------------------------------
// pcm_sample_player_16ch_top
// sixteen-voice 8-bit pcm sample player with register ram and mixer
// ----------------------------------------------------------------------------
// a write or load sets the result valid when taken; a read passes S_READ and S_RDONE;
// a tick fetches each voice's fields, a stopped voice skipping the rest after its flags,
// then decides, mixes and writes back flags, ADDRM and ADDRH. after reset a clearing pass
// fills the register ram with 0xff; no request is taken during it. one request at a time.
module pcm_sample_player_16ch_top import pcmsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	logic [4:0] bank_shift_q;
	logic [7:0] bank_mask_q;
	cmd_t       cmd;
	stat_t      stat;
	logic       clr_busy;
	out_item_t  dp_result;
	in_item_t   held;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_shift_q <= 5'd16;
			bank_mask_q  <= 8'd112;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BANK_SHIFT: bank_shift_q <= cfg_wdata[4:0];
				CFG_BANK_MASK:  bank_mask_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	pcmsp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_item(in_data),
		.out_valid, .out_ready, .out_item(out_data), .held,
		.dp_result, .stat, .clr_busy, .cmd
	);

	// read requests use the held address
	pcmsp_datapath u_dp (
		.clk, .arst_n, .cmd, .item(in_data), .held, .bank_shift(bank_shift_q),
		.bank_mask(bank_mask_q), .stat, .clr_busy, .result(dp_result)
	);

	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ready) else $error("request taken during clearing pass");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wb_flags, cmd.wb_addrm, cmd.wb_addrh, cmd.host_wr}))
		else $error("register ram write conflict");

endmodule
